// ===== rtl/gmps_pkg.sv =====
package gmps_pkg;

    // Field widths fixed by the interface
    localparam int PROFIT_W  = 16;
    localparam int TOTAL_W   = 25;
    localparam int COUNT_W   = 9;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT    = 1'b0,
        REG_COLUMN_COUNT = 1'b1
    } cfg_reg_t;

    // Position class of one cell, set by the front part
    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last_cell;
    } cell_flags_t;

endpackage

// ===== rtl/grid_max_path_sum.sv =====
// Grid maximum path sum (moves right or down only).
// Configure row_count (index 0) and column_count (index 1) on the cfg channel
// (cfg_valid/cfg_ready, always ready) while the block is idle; 0 acts as 1 and
// values above the maxima act as the maxima. Reset sets both to 1.
// Push cell profits in row-major order on push/full; an item is taken when
// push is high and full is low. One result per grid comes out on empty/pop
// with the best total to the bottom-right cell; the start cell counts zero.
// Throughput: one cell per cycle while the result queue has room. A cell
// passes the classify queue, then a two-step back part (line buffer read,
// then add/compare and write back), and its result is registered in the
// output queue before it shows on path_total. The loop that sets the rate
// is the left-total feedback through one add and one compare per cycle.
// Reset clears position counters and both queues; the line buffer is not
// cleared, since each row's entries are written before the next row reads.
// When the receiver stalls, up to four results wait; past that the back
// part stops pulling cells, the four-entry input queue fills and full rises.
module grid_max_path_sum #(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLUMNS = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [gmps_pkg::PROFIT_W-1:0] cell_profit,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [gmps_pkg::TOTAL_W-1:0]  path_total,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gmps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gmps_pkg::COUNT_W-1:0]         cfg_data
);
    import gmps_pkg::*;

    localparam int COL_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int FLAGS_W   = $bits(cell_flags_t);
    localparam int MID_W     = PROFIT_W + COL_W + FLAGS_W;
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

    logic                       accept;
    logic [COL_W-1:0]           cell_col;
    cell_flags_t                cell_flags;
    logic [MID_W-1:0]           mid_wdata, mid_rdata;
    logic                       mid_empty, mid_pop;
    logic signed [PROFIT_W-1:0] q_profit;
    logic [COL_W-1:0]           q_col;
    cell_flags_t                q_flags;
    logic [OCNT_W-1:0]          out_count;
    logic                       res_push;
    logic signed [TOTAL_W-1:0]  res_total;

    assign accept = push && !full;

    // Classify each cell by its place in the grid
    gmps_front #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .cell_col   (cell_col),
        .cell_flags (cell_flags)
    );

    // Hold classified cells between front and back
    assign mid_wdata = {cell_profit, cell_col, cell_flags};

    gmps_queue #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .wdata (mid_wdata),
        .pop   (mid_pop),
        .empty (mid_empty),
        .rdata (mid_rdata),
        .count ()
    );

    assign q_profit = mid_rdata[MID_W-1 -: PROFIT_W];
    assign q_col    = mid_rdata[FLAGS_W +: COL_W];
    assign q_flags  = cell_flags_t'(mid_rdata[FLAGS_W-1:0]);

    // Compute totals against the line buffer
    gmps_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .OUT_DEPTH   (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (mid_empty),
        .q_pop     (mid_pop),
        .q_profit  (q_profit),
        .q_col     (q_col),
        .q_flags   (q_flags),
        .out_count (out_count),
        .res_push  (res_push),
        .res_total (res_total)
    );

    // Hold results until the receiver pops them
    gmps_queue #(
        .WIDTH (TOTAL_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (),
        .wdata (res_total),
        .pop   (pop),
        .empty (empty),
        .rdata (path_total),
        .count (out_count)
    );

endmodule

// ===== rtl/gmps_queue.sv =====
module gmps_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [WIDTH-1:0]               wdata,
    input  logic                           pop,
    output logic                           empty,
    output logic [WIDTH-1:0]               rdata,
    output logic [$clog2(DEPTH+1)-1:0]     count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_en;
    logic             pop_en;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = entries_reg[rd_ptr_reg];
    assign push_en = push && !full;
    assign pop_en  = pop && !empty;

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_en && !pop_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_en && !push_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            entries_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/gmps_front.sv =====
module gmps_front #(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLUMNS = 256
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_valid,
    output logic                                          cfg_ready,
    input  logic [gmps_pkg::CFG_IDX_W-1:0]                cfg_index,
    input  logic [gmps_pkg::COUNT_W-1:0]                  cfg_data,
    input  logic                                          accept,
    output logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] cell_col,
    output gmps_pkg::cell_flags_t                         cell_flags
);
    import gmps_pkg::*;

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int POS_W  = ((ROW_W > COL_W) ? ROW_W : COL_W) + 1;
    localparam int CMP_W  = (POS_W > COUNT_W) ? POS_W : COUNT_W;

    logic [COUNT_W-1:0] row_count_reg;
    logic [COUNT_W-1:0] column_count_reg;
    logic [ROW_W-1:0]   row_pos_reg, row_pos_next;
    logic [COL_W-1:0]   col_pos_reg, col_pos_next;
    logic [CMP_W-1:0]   rows_raw, cols_raw;
    logic [CMP_W-1:0]   rows_eff, cols_eff;
    logic               last_row, last_col;

    assign cfg_ready = 1'b1;

    // Clamp configured counts into 1..maximum
    always_comb
    begin
        rows_raw = CMP_W'(row_count_reg);
        cols_raw = CMP_W'(column_count_reg);
        priority if (rows_raw == '0)
            rows_eff = CMP_W'(1);
        else if (rows_raw > CMP_W'(MAX_ROWS))
            rows_eff = CMP_W'(MAX_ROWS);
        else
            rows_eff = rows_raw;
        priority if (cols_raw == '0)
            cols_eff = CMP_W'(1);
        else if (cols_raw > CMP_W'(MAX_COLUMNS))
            cols_eff = CMP_W'(MAX_COLUMNS);
        else
            cols_eff = cols_raw;
    end

    // Classify the current cell
    assign last_col = (CMP_W'(col_pos_reg) + 1'b1) >= cols_eff;
    assign last_row = (CMP_W'(row_pos_reg) + 1'b1) >= rows_eff;

    assign cell_col             = col_pos_reg;
    assign cell_flags.first_row = (row_pos_reg == '0);
    assign cell_flags.first_col = (col_pos_reg == '0);
    assign cell_flags.last_cell = last_col && last_row;

    // Step through the grid in row-major order
    always_comb
    begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (accept)
        begin
            if (!last_col)
            begin
                col_pos_next = col_pos_reg + 1'b1;
            end
            else
            begin
                col_pos_next = '0;
                row_pos_next = last_row ? '0 : row_pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= COUNT_W'(1);
            column_count_reg <= COUNT_W'(1);
            row_pos_reg      <= '0;
            col_pos_reg      <= '0;
        end
        else
        begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
            if (cfg_valid)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                    REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                endcase
            end
        end
    end

endmodule

// ===== rtl/gmps_back.sv =====
module gmps_back #(
    parameter int MAX_COLUMNS = 256,
    parameter int OUT_DEPTH   = 4
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          q_empty,
    output logic                                          q_pop,
    input  logic signed [gmps_pkg::PROFIT_W-1:0]          q_profit,
    input  logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] q_col,
    input  gmps_pkg::cell_flags_t                         q_flags,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]                out_count,
    output logic                                          res_push,
    output logic signed [gmps_pkg::TOTAL_W-1:0]           res_total
);
    import gmps_pkg::*;

    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int OCNT_W = $clog2(OUT_DEPTH + 1) + 1;

    logic signed [TOTAL_W-1:0]  line_mem [MAX_COLUMNS];
    logic                       a_valid_reg;
    logic signed [PROFIT_W-1:0] a_profit_reg;
    logic [COL_W-1:0]           a_col_reg;
    cell_flags_t                a_flags_reg;
    logic signed [TOTAL_W-1:0]  up_reg;
    logic signed [TOTAL_W-1:0]  left_reg;
    logic signed [TOTAL_W-1:0]  profit_ext;
    logic signed [TOTAL_W-1:0]  best;
    logic signed [TOTAL_W-1:0]  total;
    logic [OCNT_W-1:0]          room_need;
    logic                       issue;

    // Issue only when every cell in flight has a result slot
    assign room_need = OCNT_W'(out_count) + OCNT_W'(a_valid_reg) + 1'b1;
    assign issue     = !q_empty && (room_need <= OCNT_W'(OUT_DEPTH));
    assign q_pop     = issue;

    // Pick the better neighbor and add the profit
    assign profit_ext = {{(TOTAL_W - PROFIT_W){a_profit_reg[PROFIT_W-1]}}, a_profit_reg};

    always_comb
    begin
        priority if (a_flags_reg.first_row && a_flags_reg.first_col)
            best = '0;
        else if (a_flags_reg.first_col)
            best = up_reg;
        else if (a_flags_reg.first_row)
            best = left_reg;
        else
            best = (up_reg > left_reg) ? up_reg : left_reg;
    end

    assign total = (a_flags_reg.first_row && a_flags_reg.first_col) ? '0 : profit_ext + best;

    assign res_push  = a_valid_reg && a_flags_reg.last_cell;
    assign res_total = total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            left_reg    <= '0;
        end
        else
        begin
            a_valid_reg <= issue;
            if (a_valid_reg)
            begin
                left_reg <= total;
            end
        end
    end

    // Read the line buffer, forwarding the total written in the same cycle
    always_ff @(posedge clk)
    begin
        if (a_valid_reg)
        begin
            line_mem[a_col_reg] <= total;
        end
        if (issue)
        begin
            a_profit_reg <= q_profit;
            a_col_reg    <= q_col;
            a_flags_reg  <= q_flags;
            up_reg       <= (a_valid_reg && (a_col_reg == q_col)) ? total : line_mem[q_col];
        end
    end

endmodule

// ===== rtl/gmps_checker.sv =====
module gmps_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 push,
    input logic                                 full,
    input logic                                 empty,
    input logic                                 pop,
    input logic signed [gmps_pkg::TOTAL_W-1:0]  path_total
);
    // Leave reset with the result queue empty and the input queue not full
    a_reset_clean: assert property (@(posedge clk)
        $rose(rst_n) |-> (empty && !full))
        else $error("queues not empty after reset");

    // Hold a waiting result while the receiver stalls
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(path_total)))
        else $error("waiting result changed or dropped");

    // Raise full only after a request was taken
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push && !full))
        else $error("full rose without an accepted request");

endmodule

bind grid_max_path_sum gmps_checker u_checker (.*);

// ===== tb/sv/grid_max_path_sum_tb.sv =====
`timescale 1ns / 1ps

module grid_max_path_sum_tb;

    import gmps_pkg::*;

    localparam int GRID_MAX      = 256;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RANDOM_ITEMS  = 200;

    localparam logic signed [PROFIT_W-1:0] PROFIT_MAX = 16'sh7FFF;
    localparam logic signed [PROFIT_W-1:0] PROFIT_MIN = 16'sh8000;

    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    logic signed [PROFIT_W-1:0] cell_profit;
    logic                       empty;
    logic                       pop;
    logic signed [TOTAL_W-1:0]  path_total;
    logic                       cfg_valid;
    logic                       cfg_ready;
    cfg_reg_t                   cfg_index;
    logic [COUNT_W-1:0]         cfg_data;

    // Grid state mirrored from the requests accepted so far
    logic [COUNT_W-1:0]         rows_setting;
    logic [COUNT_W-1:0]         cols_setting;
    logic signed [TOTAL_W-1:0]  line_sums [GRID_MAX];
    logic signed [TOTAL_W-1:0]  left_sum;
    int                         row_at;
    int                         col_at;
    logic signed [TOTAL_W-1:0]  pending_totals [$];
    logic signed [TOTAL_W-1:0]  oldest_total;

    int fail_count     = 0;
    int send_idle_pct  = 30;
    int pop_idle_pct   = 70;

    grid_max_path_sum dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cell_profit (cell_profit),
        .empty       (empty),
        .pop         (pop),
        .path_total  (path_total),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("** grid_max_path_sum: FAILED **");
        $finish;
    end

    function automatic void report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR: %s", msg);
    endfunction

    // Map a count register to the size it acts as
    function automatic int effective_count(input logic [COUNT_W-1:0] value);
        if (value == 0)
            return 1;
        if (value > GRID_MAX)
            return GRID_MAX;
        return int'(value);
    endfunction

    function automatic logic signed [PROFIT_W-1:0] random_profit();
        case ($urandom_range(0, 19))
            0:       return PROFIT_MAX;
            1:       return PROFIT_MIN;
            2:       return '0;
            3:       return -16'sd1;
            default: return PROFIT_W'($urandom);
        endcase
    endfunction

    // Advance the best-total recurrence by one cell; queue the total on the last cell
    task automatic advance_grid(input logic signed [PROFIT_W-1:0] profit);
        int                        rows;
        int                        cols;
        int                        col;
        logic signed [TOTAL_W-1:0] widened;
        logic signed [TOTAL_W-1:0] above;
        logic signed [TOTAL_W-1:0] total;
        rows    = effective_count(rows_setting);
        cols    = effective_count(cols_setting);
        col     = (col_at >= GRID_MAX) ? GRID_MAX - 1 : col_at;
        widened = profit;
        above   = line_sums[col];
        if (row_at == 0 && col == 0)
            total = '0;
        else if (col == 0)
            total = widened + above;
        else if (row_at == 0)
            total = widened + left_sum;
        else
            total = widened + ((above > left_sum) ? above : left_sum);
        line_sums[col] = total;
        left_sum       = total;
        if (col < cols - 1)
            col_at = col + 1;
        else
        begin
            col_at = 0;
            if (row_at < rows - 1)
                row_at++;
            else
            begin
                row_at = 0;
                pending_totals.push_back(total);
            end
        end
    endtask

    // Send one cell request; entered and left at a falling edge
    task automatic send_cell(input logic signed [PROFIT_W-1:0] profit);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push        <= 1'b1;
        cell_profit <= profit;
        do @(posedge clk); while (full);
        advance_grid(profit);
        @(negedge clk);
    endtask

    // Hold off until every expected total is back (or DRAIN_LIMIT runs out) and the pipeline has settled
    task automatic idle_until_drained();
        int waited;
        push   <= 1'b0;
        waited = 0;
        while (pending_totals.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Leave cfg_valid high on return; the caller drops it
    task automatic write_register(input cfg_reg_t index, input logic [COUNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            REG_ROW_COUNT:    rows_setting = value;
            REG_COLUMN_COUNT: cols_setting = value;
            default:          ;
        endcase
        @(negedge clk);
    endtask

    task automatic configure_grid(input int rows, input int cols);
        idle_until_drained();
        write_register(REG_ROW_COUNT, COUNT_W'(rows));
        write_register(REG_COLUMN_COUNT, COUNT_W'(cols));
        cfg_valid <= 1'b0;
    endtask

    // One full-width row: fills every line buffer entry, column count above the maximum
    task automatic test_full_width_row();
        configure_grid(1, 511);
        for (int i = 0; i < GRID_MAX; i++)
            send_cell((i % 2 == 0) ? PROFIT_MAX : PROFIT_MIN);
    endtask

    // Single-cell grids: zero row count acts as one, every total is zero
    task automatic test_single_cell();
        configure_grid(0, 1);
        send_cell(PROFIT_MAX);
        send_cell(PROFIT_MIN);
        send_cell('0);
        send_cell(-16'sd1);
    endtask

    // Small grid with extremes and ties between above and left
    task automatic test_small_grid();
        logic signed [PROFIT_W-1:0] cells [12] = '{
            16'sd5, PROFIT_MAX, PROFIT_MIN, 16'sd7,
            PROFIT_MIN, 16'sd0, PROFIT_MAX, -16'sd1,
            16'sd3, 16'sd3, PROFIT_MIN, PROFIT_MAX
        };
        configure_grid(3, 4);
        foreach (cells[i])
            send_cell(cells[i]);
        configure_grid(2, 2);
        send_cell(16'sd9);
        send_cell(16'sd4);
        send_cell(16'sd4);
        send_cell(16'sd1);
    endtask

    // Tall single-column grids at the row extremes
    task automatic test_tall_column();
        configure_grid(256, 1);
        repeat (GRID_MAX) send_cell(PROFIT_MAX);
        configure_grid(511, 1);
        repeat (GRID_MAX) send_cell(PROFIT_MIN);
    endtask

    // Shrink columns past the current position, then rows past the current row
    task automatic test_mid_grid_change();
        configure_grid(3, 6);
        repeat (4) send_cell(random_profit());
        configure_grid(3, 3);
        send_cell(random_profit());
        repeat (3) send_cell(random_profit());
        configure_grid(1, 3);
        repeat (3) send_cell(random_profit());
    endtask

    // Random grids, mostly small, some large, some cut off mid-grid
    task automatic test_random_grids(input int sender_idle, input int receiver_idle,
                                     input int budget);
        int sent;
        int rows;
        int cols;
        int grids;
        int cells;
        send_idle_pct = sender_idle;
        pop_idle_pct  = receiver_idle;
        sent = 0;
        while (sent < budget)
        begin
            grids = $urandom_range(1, 3);
            case ($urandom_range(0, 39))
                0:
                begin
                    rows  = $urandom_range(1, 2);
                    cols  = $urandom_range(200, 511);
                    grids = 1;
                end
                1:
                begin
                    rows  = $urandom_range(200, 511);
                    cols  = $urandom_range(1, 2);
                    grids = 1;
                end
                2, 3:
                begin
                    rows = $urandom_range(0, 1);
                    cols = $urandom_range(0, 6);
                end
                default:
                begin
                    rows = $urandom_range(1, 8);
                    cols = $urandom_range(1, 8);
                end
            endcase
            configure_grid(rows, cols);
            cells = grids * effective_count(COUNT_W'(rows)) * effective_count(COUNT_W'(cols));
            // cut a grid short now and then so the next setting lands mid-grid
            if ($urandom_range(0, 9) == 0)
                cells = $urandom_range(1, cells);
            repeat (cells) send_cell(random_profit());
            sent += cells;
        end
    endtask

    // Drive pop with the current stall rate
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            pop <= ($urandom_range(0, 99) >= pop_idle_pct);
        end
    end

    // Compare each popped total with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_totals.size() == 0)
                report_failure($sformatf("path_total %0d with none expected", path_total));
            else
            begin
                oldest_total = pending_totals.pop_front();
                if (path_total !== oldest_total)
                    report_failure($sformatf("path_total expected %0d, got %0d",
                                             oldest_total, path_total));
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        push         = 1'b0;
        cell_profit  = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_ROW_COUNT;
        cfg_data     = '0;
        rows_setting = COUNT_W'(1);
        cols_setting = COUNT_W'(1);
        left_sum     = '0;
        row_at       = 0;
        col_at       = 0;
        foreach (line_sums[i])
            line_sums[i] = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_full_width_row();
        test_single_cell();
        test_small_grid();
        test_mid_grid_change();
        test_tall_column();
        test_random_grids(30, 70, RANDOM_ITEMS);
        test_random_grids(70, 30, RANDOM_ITEMS);
        test_random_grids(0, 0, RANDOM_ITEMS);

        idle_until_drained();
        if (pending_totals.size() != 0)
            report_failure($sformatf("%0d path totals never arrived", pending_totals.size()));

        if (fail_count == 0)
            $display("** grid_max_path_sum: PASSED **");
        else
            $display("** grid_max_path_sum: FAILED **");
        $finish;
    end

endmodule
